@@ hw/rtl/ptp_pkg.sv @@
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared types, constants and tables for the pen tilt to polar converter.
// ----------------------------------------------------------------------------
package ptp_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int MAX_STAGES    = 24;
    localparam int CS            = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    localparam int LATENCY       = 2 * CS + 3;

    localparam int XW = 36;
    localparam int ZW = 25;

    localparam logic signed [XW-1:0] GAIN_Q16  = XW'(107922);
    localparam logic signed [ZW-1:0] QUAD_MAX  = ZW'(90 * 65536);
    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180 * 65536);
    localparam logic signed [ZW-1:0] HALF_Q16  = ZW'(32768);
    localparam logic signed [7:0]    DEG_LIMIT = 8'sd90;

    typedef struct packed {
        logic              zero;
        logic              neg_x;
        logic              neg_y;
        logic signed [8:0] az;
    } tag_t;

    function automatic logic [31:0] tan_rom(input logic [6:0] d);
        logic [31:0] v;
        case (d)
            7'd0: v = 32'd0;        7'd1: v = 32'd1144;     7'd2: v = 32'd2289;
            7'd3: v = 32'd3435;     7'd4: v = 32'd4583;     7'd5: v = 32'd5734;
            7'd6: v = 32'd6888;     7'd7: v = 32'd8047;     7'd8: v = 32'd9210;
            7'd9: v = 32'd10380;    7'd10: v = 32'd11556;   7'd11: v = 32'd12739;
            7'd12: v = 32'd13930;   7'd13: v = 32'd15130;   7'd14: v = 32'd16340;
            7'd15: v = 32'd17560;   7'd16: v = 32'd18792;   7'd17: v = 32'd20036;
            7'd18: v = 32'd21294;   7'd19: v = 32'd22566;   7'd20: v = 32'd23853;
            7'd21: v = 32'd25157;   7'd22: v = 32'd26478;   7'd23: v = 32'd27818;
            7'd24: v = 32'd29179;   7'd25: v = 32'd30560;   7'd26: v = 32'd31964;
            7'd27: v = 32'd33392;   7'd28: v = 32'd34846;   7'd29: v = 32'd36327;
            7'd30: v = 32'd37837;   7'd31: v = 32'd39378;   7'd32: v = 32'd40951;
            7'd33: v = 32'd42560;   7'd34: v = 32'd44205;   7'd35: v = 32'd45889;
            7'd36: v = 32'd47615;   7'd37: v = 32'd49385;   7'd38: v = 32'd51202;
            7'd39: v = 32'd53070;   7'd40: v = 32'd54991;   7'd41: v = 32'd56970;
            7'd42: v = 32'd59009;   7'd43: v = 32'd61113;   7'd44: v = 32'd63287;
            7'd45: v = 32'd65536;   7'd46: v = 32'd67865;   7'd47: v = 32'd70279;
            7'd48: v = 32'd72785;   7'd49: v = 32'd75391;   7'd50: v = 32'd78103;
            7'd51: v = 32'd80930;   7'd52: v = 32'd83882;   7'd53: v = 32'd86969;
            7'd54: v = 32'd90203;   7'd55: v = 32'd93595;   7'd56: v = 32'd97161;
            7'd57: v = 32'd100917;  7'd58: v = 32'd104880;  7'd59: v = 32'd109070;
            7'd60: v = 32'd113512;  7'd61: v = 32'd118230;  7'd62: v = 32'd123255;
            7'd63: v = 32'd128622;  7'd64: v = 32'd134369;  7'd65: v = 32'd140542;
            7'd66: v = 32'd147196;  7'd67: v = 32'd154393;  7'd68: v = 32'd162207;
            7'd69: v = 32'd170727;  7'd70: v = 32'd180059;  7'd71: v = 32'd190330;
            7'd72: v = 32'd201699;  7'd73: v = 32'd214359;  7'd74: v = 32'd228551;
            7'd75: v = 32'd244584;  7'd76: v = 32'd262851;  7'd77: v = 32'd283868;
            7'd78: v = 32'd308323;  7'd79: v = 32'd337153;  7'd80: v = 32'd371673;
            7'd81: v = 32'd413778;  7'd82: v = 32'd466313;  7'd83: v = 32'd533748;
            7'd84: v = 32'd623533;  7'd85: v = 32'd749080;  7'd86: v = 32'd937208;
            7'd87: v = 32'd1250501; 7'd88: v = 32'd1876705; 7'd89: v = 32'd3754555;
            default: v = 32'hFFFF_FFFF;
        endcase
        return v;
    endfunction

    function automatic logic signed [ZW-1:0] atan_rom(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0: v = ZW'(2949120);  1: v = ZW'(1740967);  2: v = ZW'(919879);
            3: v = ZW'(466945);   4: v = ZW'(234379);   5: v = ZW'(117265);
            6: v = ZW'(58666);    7: v = ZW'(29335);    8: v = ZW'(14668);
            9: v = ZW'(7334);     10: v = ZW'(3667);    11: v = ZW'(1833);
            12: v = ZW'(917);     13: v = ZW'(458);     14: v = ZW'(229);
            15: v = ZW'(115);     16: v = ZW'(57);      17: v = ZW'(29);
            18: v = ZW'(14);      19: v = ZW'(7);       20: v = ZW'(4);
            21: v = ZW'(2);       22: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // clamp to first quadrant and round to whole degrees
    function automatic logic [7:0] quad_round(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] a;
        logic signed [ZW-1:0] s;
        if (z < 0)
            a = '0;
        else if (z > QUAD_MAX)
            a = QUAD_MAX;
        else
            a = z;
        s = a + HALF_Q16;
        return s[23:16];
    endfunction

endpackage

@@ hw/rtl/pen_tilt_to_polar.sv @@
// ----------------------------------------------------------------------------
// pen_tilt_to_polar
// X/Y pen tilt to overall tilt and azimuth via two pipelined vectoring CORDICs.
// Start to done: front reg, azimuth CORDIC, unfolding reg, tilt CORDIC, output reg.
// Throughput: one word per cycle; busy is always low, set by the unrolled pipeline.
// Reset clears the valid bits only; no clearing pass.
// The receiver cannot stall: done marks each result for one cycle.
// ----------------------------------------------------------------------------
module pen_tilt_to_polar (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic signed [7:0] tilt_x_deg,
    input  logic signed [7:0] tilt_y_deg,
    output logic              done,
    output logic [6:0]        tilt_angle,
    output logic signed [8:0] azimuth
);

    logic                          f_valid, c1_valid, a_valid, c2_valid;
    logic signed [ptp_pkg::XW-1:0] f_x, f_y, c1_x, a_mag;
    logic signed [ptp_pkg::ZW-1:0] c1_z, c2_z;
    ptp_pkg::tag_t                 f_tag, c1_tag, a_tag, c2_tag;

    logic              done_reg;
    logic [6:0]        tilt_reg, tilt_next;
    logic signed [8:0] az_reg;
    logic [7:0]        t_round;

    assign busy = 1'b0;

    ptp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .tilt_x_deg (tilt_x_deg),
        .tilt_y_deg (tilt_y_deg),
        .out_valid  (f_valid),
        .out_x      (f_x),
        .out_y      (f_y),
        .out_tag    (f_tag)
    );

    ptp_cordic u_cordic_az (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_x      (f_x),
        .in_y      (f_y),
        .in_tag    (f_tag),
        .out_valid (c1_valid),
        .out_x     (c1_x),
        .out_z     (c1_z),
        .out_tag   (c1_tag)
    );

    ptp_azimuth u_azimuth (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c1_valid),
        .in_mag    (c1_x),
        .in_z      (c1_z),
        .in_tag    (c1_tag),
        .out_valid (a_valid),
        .out_mag   (a_mag),
        .out_tag   (a_tag)
    );

    ptp_cordic u_cordic_tilt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid),
        .in_x      (ptp_pkg::GAIN_Q16),
        .in_y      (a_mag),
        .in_tag    (a_tag),
        .out_valid (c2_valid),
        .out_x     (),
        .out_z     (c2_z),
        .out_tag   (c2_tag)
    );

    always_comb
    begin
        t_round   = ptp_pkg::quad_round(c2_z);
        tilt_next = c2_tag.zero ? 7'd0 : t_round[6:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= c2_valid;
    end

    always_ff @(posedge clk)
    begin
        tilt_reg <= tilt_next;
        az_reg   <= c2_tag.az;
    end

    assign done       = done_reg;
    assign tilt_angle = tilt_reg;
    assign azimuth    = az_reg;

`ifndef SYNTHESIS
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, ptp_pkg::LATENCY))
        else $error("word out without word in");
    a_tilt: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> tilt_angle <= 7'd90)
        else $error("tilt out of range");
    a_az: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (azimuth >= -9'sd180) && (azimuth <= 9'sd180))
        else $error("azimuth out of range");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        c2_valid && c2_tag.zero |=> tilt_angle == 7'd0 && azimuth == 9'sd0)
        else $error("zero tilt not zero");
`endif

endmodule

@@ hw/rtl/ptp_front.sv @@
// ----------------------------------------------------------------------------
// ptp_front
// Degree saturation and tangent lookup, one register stage.
// ----------------------------------------------------------------------------
module ptp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [7:0]             tilt_x_deg,
    input  logic signed [7:0]             tilt_y_deg,
    output logic                          out_valid,
    output logic signed [ptp_pkg::XW-1:0] out_x,
    output logic signed [ptp_pkg::XW-1:0] out_y,
    output ptp_pkg::tag_t                 out_tag
);

    logic                          valid_reg;
    logic signed [ptp_pkg::XW-1:0] x_reg, x_next;
    logic signed [ptp_pkg::XW-1:0] y_reg, y_next;
    ptp_pkg::tag_t                 tag_reg, tag_next;
    logic signed [7:0]             dx, dy;
    logic [6:0]                    mx, my;

    always_comb
    begin
        dx = tilt_x_deg;
        dy = tilt_y_deg;
        if (dx > ptp_pkg::DEG_LIMIT)
            dx = ptp_pkg::DEG_LIMIT;
        if (dx < -ptp_pkg::DEG_LIMIT)
            dx = -ptp_pkg::DEG_LIMIT;
        if (dy > ptp_pkg::DEG_LIMIT)
            dy = ptp_pkg::DEG_LIMIT;
        if (dy < -ptp_pkg::DEG_LIMIT)
            dy = -ptp_pkg::DEG_LIMIT;
        mx = dx[7] ? 7'(-dx) : dx[6:0];
        my = dy[7] ? 7'(-dy) : dy[6:0];
        x_next = ptp_pkg::XW'({4'b0, ptp_pkg::tan_rom(mx)});
        y_next = ptp_pkg::XW'({4'b0, ptp_pkg::tan_rom(my)});
        tag_next.zero  = (mx == 7'd0) && (my == 7'd0);
        tag_next.neg_x = dx[7];
        tag_next.neg_y = dy[7];
        tag_next.az    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        tag_reg <= tag_next;
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_tag   = tag_reg;

endmodule

@@ hw/rtl/ptp_cordic.sv @@
// ----------------------------------------------------------------------------
// ptp_cordic
// Unrolled vectoring CORDIC, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module ptp_cordic (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [ptp_pkg::XW-1:0] in_x,
    input  logic signed [ptp_pkg::XW-1:0] in_y,
    input  ptp_pkg::tag_t                 in_tag,
    output logic                          out_valid,
    output logic signed [ptp_pkg::XW-1:0] out_x,
    output logic signed [ptp_pkg::ZW-1:0] out_z,
    output ptp_pkg::tag_t                 out_tag
);

    logic                          valid_reg [0:ptp_pkg::CS];
    logic signed [ptp_pkg::XW-1:0] x_reg     [0:ptp_pkg::CS];
    logic signed [ptp_pkg::XW-1:0] y_reg     [0:ptp_pkg::CS];
    logic signed [ptp_pkg::ZW-1:0] z_reg     [0:ptp_pkg::CS];
    ptp_pkg::tag_t                 tag_reg   [0:ptp_pkg::CS];

    always_comb
    begin
        valid_reg[0] = in_valid;
        x_reg[0]     = in_x;
        y_reg[0]     = in_y;
        z_reg[0]     = '0;
        tag_reg[0]   = in_tag;
    end

    for (genvar i = 0; i < ptp_pkg::CS; i++) begin : g_stage
        logic signed [ptp_pkg::XW-1:0] xs, ys, x_next, y_next;
        logic signed [ptp_pkg::ZW-1:0] z_next;

        always_comb
        begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
            if (y_reg[i] > 0)
            begin
                x_next = x_reg[i] + ys;
                y_next = y_reg[i] - xs;
                z_next = z_reg[i] + ptp_pkg::atan_rom(i);
            end
            else
            begin
                x_next = x_reg[i] - ys;
                y_next = y_reg[i] + xs;
                z_next = z_reg[i] - ptp_pkg::atan_rom(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else
                valid_reg[i+1] <= valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1]   <= x_next;
            y_reg[i+1]   <= y_next;
            z_reg[i+1]   <= z_next;
            tag_reg[i+1] <= tag_reg[i];
        end
    end

    assign out_valid = valid_reg[ptp_pkg::CS];
    assign out_x     = x_reg[ptp_pkg::CS];
    assign out_z     = z_reg[ptp_pkg::CS];
    assign out_tag   = tag_reg[ptp_pkg::CS];

endmodule

@@ hw/rtl/ptp_azimuth.sv @@
// ----------------------------------------------------------------------------
// ptp_azimuth
// Quadrant unfolding and rounding of the azimuth; forwards the magnitude.
// ----------------------------------------------------------------------------
module ptp_azimuth (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [ptp_pkg::XW-1:0] in_mag,
    input  logic signed [ptp_pkg::ZW-1:0] in_z,
    input  ptp_pkg::tag_t                 in_tag,
    output logic                          out_valid,
    output logic signed [ptp_pkg::XW-1:0] out_mag,
    output ptp_pkg::tag_t                 out_tag
);

    logic                          valid_reg;
    logic signed [ptp_pkg::XW-1:0] mag_reg;
    ptp_pkg::tag_t                 tag_reg, tag_next;
    logic signed [ptp_pkg::ZW-1:0] a, full, s;
    logic signed [8:0]             r;

    always_comb
    begin
        if (in_z < 0)
            a = '0;
        else if (in_z > ptp_pkg::QUAD_MAX)
            a = ptp_pkg::QUAD_MAX;
        else
            a = in_z;
        full = in_tag.neg_x ? (ptp_pkg::HALF_TURN - a) : a;
        s    = full + ptp_pkg::HALF_Q16;
        r    = $signed({1'b0, s[23:16]});
        tag_next    = in_tag;
        if (in_tag.zero)
            tag_next.az = '0;
        else
            tag_next.az = in_tag.neg_y ? -r : r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= in_mag;
        tag_reg <= tag_next;
    end

    assign out_valid = valid_reg;
    assign out_mag   = mag_reg;
    assign out_tag   = tag_reg;

endmodule
